### rtl/blr_pkg.sv
// ----------------------------------------------------------------------------
// blr_pkg
// Shared types and constants for the line rasterizer: sequencer states,
// octant codes and the control group of the error term unit.
// ----------------------------------------------------------------------------
package blr_pkg;

    // coordinate width inside one tile
    localparam int COORD_W = 6;
    // decision variable width, holds a few multiples of the largest span
    localparam int ERR_W   = 10;
    // color width, 8 bits per channel
    localparam int COLOR_W = 24;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_RUN
    } blr_state_t;

    typedef enum logic [1:0] {
        OCT_STEEP_RISE,
        OCT_SHALLOW_RISE,
        OCT_SHALLOW_FALL,
        OCT_STEEP_FALL
    } blr_oct_t;

    // control group from the sequencer to the error term unit
    typedef struct packed {
        logic load;      // load the initial decision value
        logic advance;   // take one step along the major axis
        logic test_pos;  // minor step when d > 0, otherwise when d < 0
    } blr_err_ctrl_t;

endpackage

### rtl/blr_err_unit.sv
// ----------------------------------------------------------------------------
// blr_err_unit
// Error term unit: holds the decision variable, decides on each major step
// whether the minor axis moves, and adds the matching increment.
// ----------------------------------------------------------------------------
module blr_err_unit (
    input  logic                                 clk,
    input  blr_pkg::blr_err_ctrl_t               ctrl,
    input  logic signed [blr_pkg::ERR_W-1:0]     d_init,
    input  logic signed [blr_pkg::ERR_W-1:0]     inc_minor,
    input  logic signed [blr_pkg::ERR_W-1:0]     inc_major,
    output logic                                 take_minor
);
    import blr_pkg::*;

    logic signed [ERR_W-1:0] d_reg;
    logic signed [ERR_W-1:0] d_next;

    // sign test on the current decision value
    always_comb
    begin
        if (ctrl.test_pos)
        begin
            take_minor = (d_reg > 0);
        end
        else
        begin
            take_minor = (d_reg < 0);
        end
    end

    // one shared adder, increment picked by the decision
    always_comb
    begin
        priority if (ctrl.load)
        begin
            d_next = d_init;
        end
        else if (ctrl.advance)
        begin
            d_next = d_reg + (take_minor ? inc_minor : inc_major);
        end
        else
        begin
            d_next = d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

endmodule

### rtl/bresenham_line_rasterizer.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// Midpoint line rasterizer, one tile, all octants, one pixel/cycle unstalled.
// ----------------------------------------------------------------------------
// Usage:
//   A segment enters on the input channel (in_valid/in_ready) as two
//   endpoints. Endpoints are clamped to the tile, swapped so drawing runs
//   left to right, and the pixels leave on the output channel
//   (out_valid/out_ready), one item per pixel, last_pixel set on the final
//   one. Each pixel carries draw_color, written through cfg_valid/cfg_data
//   by the user only while no segment is in flight, which the block does
//   not enforce; cfg_ready is always high. The endpoints are registered
//   on acceptance and the octant is set up in S_SETUP before each pixel is
//   registered in the output register. A segment of N = max(|dx|,|dy|)+1
//   pixels is stepped by the single error term adder, one pixel per cycle
//   while the output is free. in_ready is high only while the sequencer
//   is idle. Reset clears the sequencer, the output valid and draw_color
//   to 0. When the receiver stalls the pixel is held in the output register
//   and the stepping pauses until it is taken.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer #(
    parameter int TILE_SIZE = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [blr_pkg::COLOR_W-1:0]    cfg_data,
    // segment input
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [blr_pkg::COORD_W-1:0]    start_x,
    input  logic [blr_pkg::COORD_W-1:0]    start_y,
    input  logic [blr_pkg::COORD_W-1:0]    end_x,
    input  logic [blr_pkg::COORD_W-1:0]    end_y,
    // pixel output
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [blr_pkg::COORD_W-1:0]    pixel_x,
    output logic [blr_pkg::COORD_W-1:0]    pixel_y,
    output logic [blr_pkg::COLOR_W-1:0]    pixel_color,
    output logic                           last_pixel
);
    import blr_pkg::*;

    localparam int COORD_LIMIT = (1 << COORD_W) - 1;
    localparam logic [COORD_W-1:0] CoordMax =
        (TILE_SIZE - 1 >= COORD_LIMIT) ? COORD_W'(COORD_LIMIT) : COORD_W'(TILE_SIZE - 1);

    blr_state_t              state_reg, state_next;
    blr_oct_t                oct_reg, oct_next;
    logic [COLOR_W-1:0]      color_reg, color_next;
    logic [COORD_W-1:0]      x_reg, x_next;
    logic [COORD_W-1:0]      y_reg, y_next;
    logic signed [COORD_W:0] a_reg, a_next;       // rise, y1 - y0
    logic [COORD_W-1:0]      nb_reg, nb_next;     // run, x1 - x0
    logic [COORD_W-1:0]      cnt_reg, cnt_next;   // major steps left
    logic signed [ERR_W-1:0] inc_minor_reg, inc_minor_next;
    logic signed [ERR_W-1:0] inc_major_reg, inc_major_next;
    logic                    out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]      px_reg, px_next;
    logic [COORD_W-1:0]      py_reg, py_next;
    logic [COLOR_W-1:0]      pcolor_reg, pcolor_next;
    logic                    plast_reg, plast_next;

    logic [COORD_W-1:0]      sx, sy, ex, ey;
    logic                    swap;
    logic [COORD_W-1:0]      x0, y0, x1, y1;
    logic signed [ERR_W-1:0] a_ext, b_ext;
    logic signed [COORD_W:0] neg_a;
    logic signed [ERR_W-1:0] d_init;
    logic                    out_free;
    logic                    take_minor;
    blr_err_ctrl_t           err_ctrl;

    // shared error term unit
    blr_err_unit u_err (
        .clk        (clk),
        .ctrl       (err_ctrl),
        .d_init     (d_init),
        .inc_minor  (inc_minor_reg),
        .inc_major  (inc_major_reg),
        .take_minor (take_minor)
    );

    // clamp to the tile and order endpoints left to right
    always_comb
    begin
        sx   = (start_x > CoordMax) ? CoordMax : start_x;
        sy   = (start_y > CoordMax) ? CoordMax : start_y;
        ex   = (end_x > CoordMax) ? CoordMax : end_x;
        ey   = (end_y > CoordMax) ? CoordMax : end_y;
        swap = (ex < sx);
        x0   = swap ? ex : sx;
        y0   = swap ? ey : sy;
        x1   = swap ? sx : ex;
        y1   = swap ? sy : ey;
    end

    // sign-extended rise and negated run for the setup arithmetic
    always_comb
    begin
        a_ext = ERR_W'(a_reg);
        b_ext = -signed'({{(ERR_W - COORD_W){1'b0}}, nb_reg});
        neg_a = -a_reg;
    end

    assign out_free = !out_valid_reg || out_ready;

    // sequencer: next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        oct_next       = oct_reg;
        color_next     = color_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        a_next         = a_reg;
        nb_next        = nb_reg;
        cnt_next       = cnt_reg;
        inc_minor_next = inc_minor_reg;
        inc_major_next = inc_major_reg;
        out_valid_next = out_valid_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pcolor_next    = pcolor_reg;
        plast_next     = plast_reg;
        d_init         = '0;
        err_ctrl.load  = 1'b0;
        err_ctrl.advance  = 1'b0;
        err_ctrl.test_pos = (oct_reg == OCT_SHALLOW_RISE) || (oct_reg == OCT_STEEP_FALL);

        // draw color register
        if (cfg_valid)
        begin
            color_next = cfg_data;
        end

        // output register drains independently
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next     = x0;
                    y_next     = y0;
                    a_next     = signed'({1'b0, y1}) - signed'({1'b0, y0});
                    nb_next    = x1 - x0;
                    state_next = S_SETUP;
                end
            end

            // pick the octant and load increments, count and initial decision
            S_SETUP:
            begin
                err_ctrl.load = 1'b1;
                priority if ((a_reg > 0) && (a_reg >= signed'({1'b0, nb_reg})))
                begin
                    oct_next       = OCT_STEEP_RISE;
                    d_init         = a_ext + b_ext + b_ext;
                    inc_minor_next = a_ext + a_ext + b_ext + b_ext;
                    inc_major_next = b_ext + b_ext;
                    cnt_next       = a_reg[COORD_W-1:0];
                end
                else if (a_reg >= 0 && (a_reg < signed'({1'b0, nb_reg})))
                begin
                    oct_next       = OCT_SHALLOW_RISE;
                    d_init         = a_ext + a_ext + b_ext;
                    inc_minor_next = a_ext + a_ext + b_ext + b_ext;
                    inc_major_next = a_ext + a_ext;
                    cnt_next       = nb_reg;
                end
                else if ((a_reg < 0) && (neg_a < signed'({1'b0, nb_reg})))
                begin
                    oct_next       = OCT_SHALLOW_FALL;
                    d_init         = a_ext + a_ext - b_ext;
                    inc_minor_next = a_ext + a_ext - b_ext - b_ext;
                    inc_major_next = a_ext + a_ext;
                    cnt_next       = nb_reg;
                end
                else
                begin
                    oct_next       = OCT_STEEP_FALL;
                    d_init         = a_ext - b_ext - b_ext;
                    inc_minor_next = a_ext + a_ext - b_ext - b_ext;
                    inc_major_next = -(b_ext + b_ext);
                    cnt_next       = neg_a[COORD_W-1:0];
                end
                state_next = S_RUN;
            end

            // emit one pixel per cycle while the output register is free
            S_RUN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    px_next        = x_reg;
                    py_next        = y_reg;
                    pcolor_next    = color_reg;
                    plast_next     = (cnt_reg == '0);
                    if (cnt_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        err_ctrl.advance = 1'b1;
                        cnt_next         = cnt_reg - 1'b1;
                        unique case (oct_reg)
                            OCT_STEEP_RISE:
                            begin
                                y_next = y_reg + 1'b1;
                                if (take_minor)
                                begin
                                    x_next = x_reg + 1'b1;
                                end
                            end
                            OCT_SHALLOW_RISE:
                            begin
                                x_next = x_reg + 1'b1;
                                if (take_minor)
                                begin
                                    y_next = y_reg + 1'b1;
                                end
                            end
                            OCT_SHALLOW_FALL:
                            begin
                                x_next = x_reg + 1'b1;
                                if (take_minor)
                                begin
                                    y_next = y_reg - 1'b1;
                                end
                            end
                            OCT_STEEP_FALL:
                            begin
                                y_next = y_reg - 1'b1;
                                if (take_minor)
                                begin
                                    x_next = x_reg + 1'b1;
                                end
                            end
                            default:
                            begin
                                y_next = y_reg;
                            end
                        endcase
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            color_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            color_reg     <= color_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        oct_reg       <= oct_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        a_reg         <= a_next;
        nb_reg        <= nb_next;
        cnt_reg       <= cnt_next;
        inc_minor_reg <= inc_minor_next;
        inc_major_reg <= inc_major_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        pcolor_reg    <= pcolor_next;
        plast_reg     <= plast_next;
    end

    assign cfg_ready   = 1'b1;
    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign pixel_color = pcolor_reg;
    assign last_pixel  = plast_reg;

endmodule

### rtl/blr_checker.sv
// ----------------------------------------------------------------------------
// blr_checker
// Port-level checks for the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module blr_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [blr_pkg::COORD_W-1:0]    pixel_x,
    input  logic [blr_pkg::COORD_W-1:0]    pixel_y,
    input  logic [blr_pkg::COLOR_W-1:0]    pixel_color,
    input  logic                           last_pixel
);
    import blr_pkg::*;

    // a stalled pixel item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
            && $stable(pixel_color) && $stable(last_pixel))
        else $error("stalled pixel item changed");

    // one segment at a time
    a_one_segment: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in a row");

    // no new segment while pixels other than the last are pending
    a_busy_mid_segment: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_pixel |-> !in_ready)
        else $error("ready while a segment is unfinished");

    // nothing follows the last pixel right away when no segment is under way
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_pixel && in_ready |=> !out_valid)
        else $error("pixel item right after last pixel");

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (.*);
